>>> rtl/pel_pkg.sv
`default_nettype none

package pel_pkg;

  // Entry buffer geometry
  localparam int unsigned PinCharsMax = 8;
  localparam int unsigned CharW       = 8;
  localparam int unsigned CountW      = 4;
  localparam int unsigned PinW        = PinCharsMax * CharW;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] RegStoredPin    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegStoredLength = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMaxFailures  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegLockoutTicks = 2'd3;

  localparam logic [3:0] ResetMaxFailures = 4'd3;
  localparam logic [7:0] ResetLockTicks   = 8'd10;

  // Key codes and item kinds
  localparam logic [CharW-1:0] KeyDelete = 8'h2A;
  localparam logic [CharW-1:0] KeyEnter  = 8'h23;

  localparam logic ActKey  = 1'b0;
  localparam logic ActTick = 1'b1;

  // Result item width, padded to whole bytes
  localparam int unsigned OutDataW = 24;

  typedef logic [PinCharsMax-1:0][CharW-1:0] entry_t;

endpackage

`default_nettype wire

>>> rtl/pel_match.sv
`default_nettype none

module pel_match (
  input  wire pel_pkg::entry_t                   entry_i,
  input  wire logic [pel_pkg::CountW-1:0]        count_i,
  input  wire logic [pel_pkg::PinW-1:0]          pin_i,
  input  wire logic [pel_pkg::CountW-1:0]        len_i,
  output logic                                   match_o
);

  logic [pel_pkg::PinCharsMax-1:0] byte_ok;

  // Compare each entered byte with its reference byte; unused slots pass
  always_comb begin
    for (int i = 0; i < pel_pkg::PinCharsMax; i++) begin
      byte_ok[i] = (pel_pkg::CountW'(i) >= count_i) ||
                   (entry_i[i] == pin_i[i*pel_pkg::CharW +: pel_pkg::CharW]);
    end
  end

  assign match_o = (count_i == len_i) && (&byte_ok);

endmodule

`default_nettype wire

>>> rtl/pin_entry_lockout.sv
// An accepted input item waits in the input register, then its result item waits
// in the result register. Throughput: one item per cycle while m_axis_tready
// holds; the entry, failure and lockout state is updated as the item moves across.
// Reset (rst_ni low, asynchronous): entry, counters and granted flag clear;
// stored PIN and length clear, max failures 3, lockout ticks 10.
`default_nettype none

module pin_entry_lockout (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,

  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [pel_pkg::CharW-1:0]         s_axis_tdata,  // [7:0] key_code
  input  wire logic                              s_axis_tuser,  // [0] action

  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [0] granted, [1] fail_event, [2] locked, [10:3] lock_remaining,
  // [14:11] entered_length, [18:15] failure_count, [23:19] zero
  output logic [pel_pkg::OutDataW-1:0]           m_axis_tdata,

  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [pel_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [pel_pkg::CfgDataW-1:0]      cfg_data_i
);

  // Configuration registers
  logic [pel_pkg::PinW-1:0]   pin_q;
  logic [pel_pkg::CountW-1:0] pin_len_q;
  logic [3:0]                 max_fail_q;
  logic [7:0]                 lock_ticks_q;

  // Input register
  logic                       in_vld_q;
  logic                       in_act_q;
  logic [pel_pkg::CharW-1:0]  in_key_q;

  // Block state
  pel_pkg::entry_t            entry_q, entry_d;
  logic [pel_pkg::CountW-1:0] entry_cnt_q, entry_cnt_d;
  logic [3:0]                 fail_cnt_q, fail_cnt_d;
  logic [7:0]                 lock_cnt_q, lock_cnt_d;
  logic                       granted_q, granted_d;
  logic                       fail_evt_d;

  // Result register
  logic                       out_vld_q;
  logic [pel_pkg::OutDataW-1:0] out_data_q;

  logic                       advance;
  logic                       match;
  logic [3:0]                 fail_inc;
  logic [2:0]                 last_idx;
  logic [2:0]                 next_idx;

  assign cfg_ready_o   = 1'b1;
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_q        <= '0;
      pin_len_q    <= '0;
      max_fail_q   <= pel_pkg::ResetMaxFailures;
      lock_ticks_q <= pel_pkg::ResetLockTicks;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pel_pkg::RegStoredPin:    pin_q        <= cfg_data_i;
        pel_pkg::RegStoredLength: pin_len_q    <= cfg_data_i[pel_pkg::CountW-1:0];
        pel_pkg::RegMaxFailures:  max_fail_q   <= cfg_data_i[3:0];
        pel_pkg::RegLockoutTicks: lock_ticks_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Capture the input item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_act_q <= s_axis_tuser;
      in_key_q <= s_axis_tdata;
    end
  end

  pel_match u_match (
    .entry_i (entry_q),
    .count_i (entry_cnt_q),
    .pin_i   (pin_q),
    .len_i   (pin_len_q),
    .match_o (match)
  );

  assign fail_inc = (fail_cnt_q == 4'hF) ? 4'hF : fail_cnt_q + 4'd1;
  assign last_idx = 3'(entry_cnt_q - 4'd1);
  assign next_idx = entry_cnt_q[2:0];

  // Work out the next state for the held item
  always_comb begin
    entry_d     = entry_q;
    entry_cnt_d = entry_cnt_q;
    fail_cnt_d  = fail_cnt_q;
    lock_cnt_d  = lock_cnt_q;
    granted_d   = granted_q;
    fail_evt_d  = 1'b0;
    if (!granted_q) begin
      if (in_act_q == pel_pkg::ActTick) begin
        if (lock_cnt_q != 8'd0) begin
          lock_cnt_d = lock_cnt_q - 8'd1;
          if (lock_cnt_q == 8'd1) begin
            fail_cnt_d = 4'd0;
          end
        end
      end else if (lock_cnt_q == 8'd0) begin
        if (in_key_q == pel_pkg::KeyDelete) begin
          if (entry_cnt_q != 4'd0) begin
            entry_cnt_d       = entry_cnt_q - 4'd1;
            entry_d[last_idx] = '0;
          end
        end else if (in_key_q == pel_pkg::KeyEnter) begin
          if (match) begin
            granted_d = 1'b1;
          end else begin
            fail_evt_d  = 1'b1;
            entry_cnt_d = '0;
            entry_d     = '0;
            fail_cnt_d  = fail_inc;
            if (fail_inc >= max_fail_q) begin
              lock_cnt_d = lock_ticks_q;
              if (lock_ticks_q == 8'd0) begin
                fail_cnt_d = 4'd0;
              end
            end
          end
        end else if (entry_cnt_q < pel_pkg::CountW'(pel_pkg::PinCharsMax)) begin
          entry_d[next_idx] = in_key_q;
          entry_cnt_d       = entry_cnt_q + 4'd1;
        end
      end
    end
  end

  // Advance the state when the item moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q     <= '0;
      entry_cnt_q <= '0;
      fail_cnt_q  <= '0;
      lock_cnt_q  <= '0;
      granted_q   <= 1'b0;
    end else if (advance) begin
      entry_q     <= entry_d;
      entry_cnt_q <= entry_cnt_d;
      fail_cnt_q  <= fail_cnt_d;
      lock_cnt_q  <= lock_cnt_d;
      granted_q   <= granted_d;
    end
  end

  // Hold the result item until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {5'd0, fail_cnt_d, entry_cnt_d, lock_cnt_d,
                     (lock_cnt_d != 8'd0), fail_evt_d, granted_d};
    end
  end

`ifndef ASSERT_OFF
  // Access, once granted, stays granted
  a_granted_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    granted_q |=> granted_q)
    else $error("granted flag dropped");

  // A lockout only follows a failed submission, which empties the entry
  a_locked_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lock_cnt_q != 8'd0) |-> (entry_cnt_q == 4'd0))
    else $error("entry not empty while locked");

  // A failure result reports an empty entry
  a_fail_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_data_q[1]) |-> (out_data_q[14:11] == 4'd0))
    else $error("failed submission left characters");

  // Access is never granted during a lockout
  a_grant_unlocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(granted_q) |-> (lock_cnt_q == 8'd0))
    else $error("granted while locked");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`default_nettype none

module tb;
  import pel_pkg::*;

  localparam int unsigned CycleLimit = 500000;

  // Result item, fields from the lowest bit up: granted, fail_event, locked,
  // lock_remaining, entered_length, failure_count, zero padding
  typedef struct packed {
    logic [4:0]       pad;
    logic [CountW-1:0] failures;
    logic [CountW-1:0] entered;
    logic [7:0]       remaining;
    logic             locked;
    logic             fail_event;
    logic             granted;
  } lock_status_t;

  // Keypad lock predictor and queue of expected status items
  class pin_lock_scoreboard;
    logic [PinW-1:0]   pin;
    logic [CountW-1:0] pin_len;
    logic [3:0]        fail_limit;
    logic [7:0]        lock_ticks;
    logic [CharW-1:0]  chars [PinCharsMax];
    logic [CountW-1:0] count;
    logic [3:0]        wrong;
    logic [7:0]        lock_left;
    bit                granted;
    lock_status_t      status_q[$];
    int                errors;
    int                checked;
    int                fail_events;
    int                lockouts;

    function new();
      pin        = '0;
      pin_len    = '0;
      fail_limit = ResetMaxFailures;
      lock_ticks = ResetLockTicks;
      foreach (chars[i]) chars[i] = '0;
      count      = '0;
      wrong      = '0;
      lock_left  = '0;
      granted    = 1'b0;
      errors     = 0;
      checked    = 0;
      fail_events = 0;
      lockouts   = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegStoredPin:    pin        = data;
        RegStoredLength: pin_len    = data[3:0];
        RegMaxFailures:  fail_limit = data[3:0];
        RegLockoutTicks: lock_ticks = data[7:0];
        default: ;
      endcase
    endfunction

    // Compare the entry with the stored PIN, length first
    function bit entry_matches();
      if (count != pin_len) return 1'b0;
      for (int i = 0; i < count; i++) begin
        if (chars[i] != pin[8*i +: 8]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function bit enter_grants();
      return !granted && lock_left == 0 && entry_matches();
    endfunction

    // Advance the lock state by one accepted item and queue its status
    function void note_input(logic act, logic [CharW-1:0] key);
      lock_status_t s;
      bit fail;
      fail = 1'b0;
      if (!granted) begin
        if (act == ActTick) begin
          if (lock_left != 0) begin
            lock_left--;
            if (lock_left == 0) wrong = '0;
          end
        end else if (lock_left == 0) begin
          if (key == KeyDelete) begin
            if (count > 0) begin
              count--;
              chars[count[2:0]] = '0;
            end
          end else if (key == KeyEnter) begin
            if (entry_matches()) begin
              granted = 1'b1;
            end else begin
              fail = 1'b1;
              fail_events++;
              count = '0;
              foreach (chars[i]) chars[i] = '0;
              if (wrong < 15) wrong++;
              if (wrong >= fail_limit) begin
                lock_left = lock_ticks;
                if (lock_left == 0) wrong = '0;
                else lockouts++;
              end
            end
          end else if (count < PinCharsMax) begin
            chars[count[2:0]] = key;
            count++;
          end
        end
      end
      s            = '0;
      s.granted    = granted;
      s.fail_event = fail;
      s.locked     = (lock_left != 0);
      s.remaining  = lock_left;
      s.entered    = count;
      s.failures   = wrong;
      status_q.push_back(s);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("MISMATCH at result %0d: %s", checked, msg);
    endtask

    task check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // Compare one result item with the oldest expected status
    task check_result(logic [OutDataW-1:0] data);
      lock_status_t got;
      lock_status_t want;
      got = data;
      if (status_q.size() == 0) begin
        report($sformatf("result %h with no item pending", data));
        return;
      end
      want = status_q.pop_front();
      check_field("granted", 8'(got.granted), 8'(want.granted));
      check_field("fail_event", 8'(got.fail_event), 8'(want.fail_event));
      check_field("locked", 8'(got.locked), 8'(want.locked));
      check_field("lock_remaining", got.remaining, want.remaining);
      check_field("entered_length", 8'(got.entered), 8'(want.entered));
      check_field("failure_count", 8'(got.failures), 8'(want.failures));
      check_field("padding", 8'(got.pad), 8'(want.pad));
      checked++;
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [CharW-1:0]    s_axis_tdata;   // [7:0] key_code
  logic                s_axis_tuser;   // [0] action
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // [0] granted .. [18:15] failure_count
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  pin_lock_scoreboard sb;
  bit  calm;
  bit  allow_grant;
  int  long_hold;
  int  items_sent;
  int  settings_used;
  int  cycle_count;

  pin_entry_lockout dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // End the run at the cycle limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(logic act, logic [CharW-1:0] key);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (!allow_grant && act == ActKey && key == KeyEnter && sb.enter_grants()) key = KeyDelete;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = act;
    s_axis_tdata  = key;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(act, key);
    items_sent++;
  endtask

  task automatic press(logic [CharW-1:0] key);
    send_item(ActKey, key);
  endtask

  // Drop valid and wait until every expected status item is back
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Type a PIN close to the stored one, or tick away a running lockout
  task automatic send_attempt();
    int len;
    int slip;
    logic [CharW-1:0] c;
    if (sb.lock_left != 0) begin
      if ($urandom_range(0, 9) < 8) send_item(ActTick, CharW'($urandom));
      else press(CharW'($urandom));
      return;
    end
    len = int'(sb.pin_len);
    case ($urandom_range(0, 3))
      0: len = len + 1;
      1: if (len > 0) len = len - 1;
      default: ;
    endcase
    if (len > 9) len = 9;
    slip = $urandom_range(0, len);
    for (int i = 0; i < len; i++) begin
      c = (i < 8) ? sb.pin[8*i +: 8] : CharW'($urandom);
      if (i == slip) c = c ^ (8'h01 << $urandom_range(0, 7));
      if ($urandom_range(0, 7) == 0) begin
        press(CharW'($urandom));
        press(KeyDelete);
      end
      press(c);
    end
    if ($urandom_range(0, 5) == 0) send_item(ActTick, CharW'($urandom));
    press(KeyEnter);
  endtask

  // Random item with the control keys weighted up
  task automatic send_noise();
    logic [CharW-1:0] key;
    case ($urandom_range(0, 3))
      0: key = KeyEnter;
      1: key = KeyDelete;
      default: key = CharW'($urandom);
    endcase
    send_item(1'($urandom_range(0, 1)), key);
  endtask

  // Load one register setting per phase, extremes included
  task automatic configure(int phase);
    logic [PinW-1:0] pin;
    int len;
    int limit;
    int ticks;
    case (phase)
      0: begin len = 4;  limit = 2;  ticks = 5;   end
      1: begin len = 8;  limit = 1;  ticks = 1;   end
      2: begin len = 0;  limit = 3;  ticks = 0;   end
      3: begin len = 11; limit = 15; ticks = 7;   end
      4: begin len = 1;  limit = 0;  ticks = 255; end
      5: begin len = 6;  limit = 15; ticks = 12;  end
      6: begin len = 15; limit = 4;  ticks = 0;   end
      default: begin len = 3; limit = 1; ticks = 2; end
    endcase
    if (phase % 2 == 0) begin
      for (int i = 0; i < PinCharsMax; i++) begin
        pin[8*i +: 8] = 8'h30 + 8'($urandom_range(0, 9));
      end
    end else begin
      pin = {$urandom, $urandom};
    end
    cfg_write(RegStoredPin, pin);
    cfg_write(RegStoredLength, CfgDataW'(len));
    cfg_write(RegMaxFailures, CfgDataW'(limit));
    cfg_write(RegLockoutTicks, CfgDataW'(ticks));
    settings_used++;
  endtask

  task automatic run_phase(int phase, int n_items);
    int target;
    wait_drained();
    configure(phase);
    calm = (phase == 1) || ($urandom_range(0, 2) == 0);
    // Hold the receiver off for a long stretch so the input backs up
    if (phase == 1) long_hold = 80;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 80) send_attempt();
      else send_noise();
    end
  endtask

  // Receive status items with random stalls and check each one
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold > 0) begin
        stall = long_hold;
        long_hold = 0;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 13);
      end
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata);
    end
  end

  // Stimulus
  initial begin
    logic [PinW-1:0] pin;
    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ActKey;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = RegStoredPin;
    cfg_data_i    = '0;
    calm          = 1'b0;
    allow_grant   = 1'b0;
    long_hold     = 0;
    items_sent    = 0;
    settings_used = 0;
    pin           = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Tick while unlocked and delete on an empty entry, reset settings
    send_item(ActTick, 8'h00);
    press(KeyDelete);
    wait_drained();
    cfg_write(RegStoredPin, {32'h0, 8'h32, 8'h31, 8'hFF, 8'h00});
    cfg_write(RegStoredLength, CfgDataW'(4));
    cfg_write(RegMaxFailures, CfgDataW'(2));
    cfg_write(RegLockoutTicks, CfgDataW'(3));
    settings_used++;

    // Edit the entry, submit a wrong PIN, overfill the entry
    press(8'h00);
    press(8'hFF);
    press(8'h31);
    press(KeyDelete);
    press(8'h31);
    press(8'h33);
    press(KeyEnter);
    for (int i = 0; i < 9; i++) press(8'hA0 + 8'(i));
    // Second miss locks; keys are discarded until the ticks run out
    press(KeyEnter);
    press(8'h31);
    press(KeyEnter);
    repeat (3) send_item(ActTick, 8'hFF);

    for (int p = 0; p < 8; p++) run_phase(p, 250);

    // Finish by entering the right PIN; nothing may change afterwards
    wait_drained();
    for (int i = 0; i < PinCharsMax; i++) pin[8*i +: 8] = 8'h30 + 8'($urandom_range(0, 9));
    cfg_write(RegStoredPin, pin);
    cfg_write(RegStoredLength, CfgDataW'(4));
    cfg_write(RegMaxFailures, CfgDataW'(15));
    cfg_write(RegLockoutTicks, CfgDataW'(255));
    settings_used++;
    calm = 1'b0;
    while (sb.lock_left != 0) send_item(ActTick, CharW'($urandom));
    repeat (PinCharsMax) press(KeyDelete);
    allow_grant = 1'b1;
    for (int i = 0; i < 4; i++) press(pin[8*i +: 8]);
    press(KeyEnter);
    press(pin[7:0]);
    send_item(ActTick, 8'h5A);
    press(KeyEnter);
    press(KeyDelete);

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d items over %0d register settings, %0d results checked.",
             items_sent, settings_used, sb.checked);
    $display("Saw %0d wrong submissions and %0d lockouts; access granted at the end: %0d.",
             sb.fail_events, sb.lockouts, sb.granted);
    if (sb.errors == 0 && sb.status_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
rtl/pel_pkg.sv
rtl/pel_match.sv
rtl/pin_entry_lockout.sv
tb/sv/tb.sv
